// File: rtl/tasms_pkg.sv
`default_nettype none

package tasms_pkg;

    // Defaults for the top-level parameters.
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF    = 20;

    // Fixed field widths of the streams and of the registers.
    localparam int TARGET_WIDTH    = 16;
    localparam int HALF_WIDTH      = 20;
    localparam int UNIT_WIDTH      = 8;
    localparam int IN_DATA_WIDTH   = 40;
    localparam int IN_USER_WIDTH   = 2;
    localparam int OUT_DATA_WIDTH  = 8;
    localparam int RESULT_WIDTH    = 6;
    localparam int APB_ADDR_WIDTH  = 4;
    localparam int APB_DATA_WIDTH  = 32;

    // Command codes carried on the input tuser.
    localparam logic [IN_USER_WIDTH-1:0] OP_TICK = 2'd0;
    localparam logic [IN_USER_WIDTH-1:0] OP_MOVE = 2'd1;
    localparam logic [IN_USER_WIDTH-1:0] OP_HOME = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_MM_PER_PULSE = 2'd1;
    localparam logic [1:0] REG_DEG_PER_PULSE = 2'd2;

    // Register reset values.
    localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = 20'd500000;
    localparam logic [UNIT_WIDTH-1:0] UNIT_RESET        = 8'd1;

    // Sequencer of the shared divider.
    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_ABS,
        CTRL_DIV_X,
        CTRL_DIV_A,
        CTRL_DONE
    } ctrl_state_t;

    // Motion mode of the step generator.
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_HOME
    } seq_mode_t;

endpackage

`default_nettype wire

// File: rtl/two_axis_stepper_move_sequencer_core.sv
// Two-axis step/direction sequencer for a translation and a rotation stepper.
// Input stream: one beat per event. tuser carries the command code (tick of one
// microsecond, move, home); tdata carries the move targets and the sampled home
// switch. Every accepted beat produces exactly one output beat with the step
// and direction pin levels, the busy flag and a flag for a dropped command.
// Ticks, home commands, unknown codes and commands dropped while busy give their
// output beat in the cycle after acceptance. A move command taken while idle is
// worked through one shared restoring divider, one quotient bit per cycle,
// translation first and rotation second; the beat is written once both
// divisions are done, and s_axis_tready stays low until the sequencer is idle.
// The output beat sits in a register, so a new input beat is taken in the same
// cycle in which the previous output beat leaves; while the receiver stalls
// with a full output register, s_axis_tready is low and nothing is lost.
// Reset clears positions, pulse counters and the sequencer, drives all pins
// forward and low, and loads the registers with their defaults (half period
// of 500000 ticks, one unit per pulse on both axes). No clearing pass is needed.
// Registers on the APB port: 0x0 half period, 0x4 mm per pulse, 0x8 degrees
// per pulse; write them only while no move or homing is in progress.
`default_nettype none

module two_axis_stepper_move_sequencer_core #(
    parameter int POSITION_WIDTH = tasms_pkg::POSITION_WIDTH_DEF,
    parameter int TIMER_WIDTH    = tasms_pkg::TIMER_WIDTH_DEF
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    // Input stream.
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: target_x [15:0], target_angle [31:16], home_switch [32], zero [39:33]
    input  wire  [tasms_pkg::IN_DATA_WIDTH-1:0]      s_axis_tdata,
    // tuser: opcode [1:0]
    input  wire  [tasms_pkg::IN_USER_WIDTH-1:0]      s_axis_tuser,
    // Output stream.
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    // tdata: step_translate [0], step_rotate [1], dir_translate_back [2],
    //        dir_rotate_back [3], busy_res [4], command_ignored [5], zero [7:6]
    output logic [tasms_pkg::OUT_DATA_WIDTH-1:0]     m_axis_tdata,
    // Register port.
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire  [tasms_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  wire  [tasms_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [tasms_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                     pready
);

    // Magnitude of a delta, width of the divider, and width of the pulse counters.
    localparam int MAG_W   = (POSITION_WIDTH > tasms_pkg::TARGET_WIDTH) ?
                             POSITION_WIDTH : tasms_pkg::TARGET_WIDTH;
    localparam int DELTA_W = MAG_W + 1;
    localparam int CNT_W   = POSITION_WIDTH + 1;
    localparam int DCNT_W  = $clog2(MAG_W);
    localparam int UW      = tasms_pkg::UNIT_WIDTH;
    localparam int HW      = tasms_pkg::HALF_WIDTH;
    localparam logic [32:0] TIMER_TOP = (33'd1 << TIMER_WIDTH) - 33'd1;

    // Stream fields.
    logic                                  in_fire;
    logic                                  out_fire;
    logic [tasms_pkg::IN_USER_WIDTH-1:0]   opcode;
    logic signed [tasms_pkg::TARGET_WIDTH-1:0] target_x;
    logic signed [tasms_pkg::TARGET_WIDTH-1:0] target_angle;
    logic                                  home_switch;

    // Registers.
    logic [HW-1:0]  half_period_reg;
    logic [UW-1:0]  mm_per_pulse_reg;
    logic [UW-1:0]  deg_per_pulse_reg;
    logic           cfg_write;

    // Sequencer and motion state.
    tasms_pkg::ctrl_state_t ctrl_state_reg, ctrl_state_next;
    tasms_pkg::seq_mode_t   mode_reg, mode_next;
    logic [1:0]                        dir_reg, dir_next;
    logic                              step_reg, step_next;
    logic [TIMER_WIDTH-1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]                  cnt_t_reg, cnt_t_next;
    logic [CNT_W-1:0]                  cnt_r_reg, cnt_r_next;
    logic signed [POSITION_WIDTH-1:0]  pos_x_reg, pos_x_next;
    logic signed [POSITION_WIDTH-1:0]  pos_a_reg, pos_a_next;

    // Move preparation and divider.
    logic signed [DELTA_W-1:0] delta_x_reg, delta_x_next;
    logic signed [DELTA_W-1:0] delta_a_reg, delta_a_next;
    logic [MAG_W-1:0]          mag_a_reg, mag_a_next;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_a;
    logic                      back_x_reg, back_x_next;
    logic                      back_a_reg, back_a_next;
    logic [MAG_W-1:0]          div_q_reg, div_q_next;
    logic [UW-1:0]             div_r_reg, div_r_next;
    logic [DCNT_W-1:0]         div_cnt_reg, div_cnt_next;
    logic [MAG_W-1:0]          quo_x_reg, quo_x_next;
    logic                      div_last;
    logic [UW-1:0]             unit_sel;
    logic [UW-1:0]             divisor;
    logic [UW:0]               div_shift;
    logic [UW+1:0]             div_diff;
    logic                      div_ok;
    logic [UW-1:0]             div_r_step;
    logic [MAG_W-1:0]          div_q_step;
    logic [CNT_W+MAG_W-1:0]    quo_x_wide;
    logic [CNT_W+MAG_W-1:0]    quo_a_wide;

    // Pulse timing.
    logic [32:0]               half_sat;
    logic [TIMER_WIDTH-1:0]    half_eff;
    logic [TIMER_WIDTH-1:0]    phase_inc;
    logic                      phase_done;
    logic [CNT_W-1:0]          cnt_t_dec;
    logic [CNT_W-1:0]          cnt_r_dec;

    // Output register.
    logic                                 out_valid_reg, out_valid_next;
    logic [tasms_pkg::RESULT_WIDTH-1:0]   out_data_reg, out_data_next;
    logic                                 res_write;
    logic                                 res_ignored;
    logic                                 go_idle;
    logic                                 clear_pos;

    // Pin levels seen after an item: the active axis is translation while its
    // pulses remain (or while homing), then rotation.
    function automatic logic [tasms_pkg::RESULT_WIDTH-1:0] pin_levels(
        input tasms_pkg::seq_mode_t mode,
        input logic [CNT_W-1:0]     cnt_t,
        input logic [CNT_W-1:0]     cnt_r,
        input logic                 step,
        input logic [1:0]           dir,
        input logic                 ignored
    );
        logic mv;
        logic t_act;
        logic r_act;
        mv    = (mode == tasms_pkg::MODE_MOVE);
        t_act = (mode == tasms_pkg::MODE_HOME) || (mv && (cnt_t != '0));
        r_act = mv && (cnt_t == '0) && (cnt_r != '0);
        return {ignored, (mode != tasms_pkg::MODE_IDLE), r_act & dir[1], t_act & dir[0],
                r_act & step, t_act & step};
    endfunction

    assign opcode       = s_axis_tuser;
    assign target_x     = s_axis_tdata[15:0];
    assign target_angle = s_axis_tdata[31:16];
    assign home_switch  = s_axis_tdata[32];

    assign s_axis_tready = (ctrl_state_reg == tasms_pkg::CTRL_IDLE) &&
                           (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(tasms_pkg::OUT_DATA_WIDTH - tasms_pkg::RESULT_WIDTH){1'b0}},
                            out_data_reg};

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= tasms_pkg::HALF_PERIOD_RESET;
            mm_per_pulse_reg  <= tasms_pkg::UNIT_RESET;
            deg_per_pulse_reg <= tasms_pkg::UNIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                tasms_pkg::REG_HALF_PERIOD:   half_period_reg   <= pwdata[HW-1:0];
                tasms_pkg::REG_MM_PER_PULSE:  mm_per_pulse_reg  <= pwdata[UW-1:0];
                tasms_pkg::REG_DEG_PER_PULSE: deg_per_pulse_reg <= pwdata[UW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tasms_pkg::REG_HALF_PERIOD:
                prdata = {{(tasms_pkg::APB_DATA_WIDTH - HW){1'b0}}, half_period_reg};
            tasms_pkg::REG_MM_PER_PULSE:
                prdata = {{(tasms_pkg::APB_DATA_WIDTH - UW){1'b0}}, mm_per_pulse_reg};
            tasms_pkg::REG_DEG_PER_PULSE:
                prdata = {{(tasms_pkg::APB_DATA_WIDTH - UW){1'b0}}, deg_per_pulse_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared divider: one restoring step per cycle. The remainder stays below
    // the divisor, so eight bits hold it; a unit of zero divides as one.
    // ------------------------------------------------------------------
    assign unit_sel   = (ctrl_state_reg == tasms_pkg::CTRL_DIV_A) ? deg_per_pulse_reg
                                                                 : mm_per_pulse_reg;
    assign divisor    = (unit_sel == '0) ? UW'(1) : unit_sel;
    assign div_shift  = {div_r_reg, div_q_reg[MAG_W-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, divisor};
    assign div_ok     = !div_diff[UW+1];
    assign div_r_step = div_ok ? div_diff[UW-1:0] : div_shift[UW-1:0];
    assign div_q_step = {div_q_reg[MAG_W-2:0], div_ok};
    assign div_last   = (div_cnt_reg == DCNT_W'(MAG_W - 1));

    // Absolute deltas, and quotients cut to the pulse counter width.
    assign mag_x      = delta_x_reg[DELTA_W-1] ? MAG_W'(-delta_x_reg) : MAG_W'(delta_x_reg);
    assign mag_a      = delta_a_reg[DELTA_W-1] ? MAG_W'(-delta_a_reg) : MAG_W'(delta_a_reg);
    assign quo_x_wide = {{CNT_W{1'b0}}, quo_x_reg};
    assign quo_a_wide = {{CNT_W{1'b0}}, div_q_reg};

    // ------------------------------------------------------------------
    // Pulse timing: a half period of zero acts as one tick, and values above
    // the timer range saturate. A wrapped phase counter also ends the half.
    // ------------------------------------------------------------------
    assign half_sat   = ({13'b0, half_period_reg} > TIMER_TOP) ? TIMER_TOP
                                                               : {13'b0, half_period_reg};
    assign half_eff   = (half_sat == '0) ? TIMER_WIDTH'(1) : TIMER_WIDTH'(half_sat);
    assign phase_inc  = phase_reg + TIMER_WIDTH'(1);
    assign phase_done = (phase_inc >= half_eff) || (phase_inc == '0);

    // At the end of a low half, translation pulses are spent first.
    assign cnt_t_dec  = (cnt_t_reg != '0) ? cnt_t_reg - CNT_W'(1) : cnt_t_reg;
    assign cnt_r_dec  = ((cnt_t_reg == '0) && (cnt_r_reg != '0)) ? cnt_r_reg - CNT_W'(1)
                                                                 : cnt_r_reg;

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl_state_next = ctrl_state_reg;
        unique case (ctrl_state_reg)
            tasms_pkg::CTRL_IDLE:
            begin
                if (in_fire && (opcode == tasms_pkg::OP_MOVE) &&
                    (mode_reg == tasms_pkg::MODE_IDLE))
                begin
                    ctrl_state_next = tasms_pkg::CTRL_ABS;
                end
            end
            tasms_pkg::CTRL_ABS:
                ctrl_state_next = tasms_pkg::CTRL_DIV_X;
            tasms_pkg::CTRL_DIV_X:
            begin
                if (div_last)
                begin
                    ctrl_state_next = tasms_pkg::CTRL_DIV_A;
                end
            end
            tasms_pkg::CTRL_DIV_A:
            begin
                if (div_last)
                begin
                    ctrl_state_next = tasms_pkg::CTRL_DONE;
                end
            end
            tasms_pkg::CTRL_DONE:
                ctrl_state_next = tasms_pkg::CTRL_IDLE;
            default:
                ctrl_state_next = tasms_pkg::CTRL_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: motion state, divider and result register.
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next    = mode_reg;
        dir_next     = dir_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        cnt_t_next   = cnt_t_reg;
        cnt_r_next   = cnt_r_reg;
        pos_x_next   = pos_x_reg;
        pos_a_next   = pos_a_reg;
        delta_x_next = delta_x_reg;
        delta_a_next = delta_a_reg;
        mag_a_next   = mag_a_reg;
        back_x_next  = back_x_reg;
        back_a_next  = back_a_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_cnt_next = div_cnt_reg;
        quo_x_next   = quo_x_reg;
        res_write    = 1'b0;
        res_ignored  = 1'b0;
        go_idle      = 1'b0;
        clear_pos    = 1'b0;

        unique case (ctrl_state_reg)
            tasms_pkg::CTRL_IDLE:
            begin
                if (in_fire)
                begin
                    res_write = 1'b1;
                    unique case (opcode)
                        tasms_pkg::OP_MOVE:
                        begin
                            if (mode_reg != tasms_pkg::MODE_IDLE)
                            begin
                                res_ignored = 1'b1;
                            end
                            else
                            begin
                                // The beat is answered once both divisions are done.
                                res_write    = 1'b0;
                                delta_x_next = DELTA_W'(target_x) - DELTA_W'(pos_x_reg);
                                delta_a_next = DELTA_W'(target_angle) - DELTA_W'(pos_a_reg);
                                pos_x_next   = POSITION_WIDTH'(target_x);
                                pos_a_next   = POSITION_WIDTH'(target_angle);
                            end
                        end
                        tasms_pkg::OP_HOME:
                        begin
                            if (mode_reg != tasms_pkg::MODE_IDLE)
                            begin
                                res_ignored = 1'b1;
                            end
                            else if (home_switch)
                            begin
                                clear_pos = 1'b1;
                                go_idle   = 1'b1;
                            end
                            else
                            begin
                                mode_next  = tasms_pkg::MODE_HOME;
                                dir_next   = 2'b01;
                                step_next  = 1'b1;
                                phase_next = '0;
                            end
                        end
                        tasms_pkg::OP_TICK:
                        begin
                            if (mode_reg != tasms_pkg::MODE_IDLE)
                            begin
                                phase_next = phase_inc;
                                if (phase_done)
                                begin
                                    phase_next = '0;
                                    if (step_reg)
                                    begin
                                        step_next = 1'b0;
                                    end
                                    else if (mode_reg == tasms_pkg::MODE_HOME)
                                    begin
                                        // Homing checks the switch after each full pulse.
                                        if (home_switch)
                                        begin
                                            clear_pos = 1'b1;
                                            go_idle   = 1'b1;
                                        end
                                        else
                                        begin
                                            step_next = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        cnt_t_next = cnt_t_dec;
                                        cnt_r_next = cnt_r_dec;
                                        if ((cnt_t_dec == '0) && (cnt_r_dec == '0))
                                        begin
                                            go_idle = 1'b1;
                                        end
                                        else
                                        begin
                                            step_next = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tasms_pkg::CTRL_ABS:
            begin
                back_x_next  = delta_x_reg[DELTA_W-1];
                back_a_next  = delta_a_reg[DELTA_W-1];
                mag_a_next   = mag_a;
                div_q_next   = mag_x;
                div_r_next   = '0;
                div_cnt_next = '0;
            end
            tasms_pkg::CTRL_DIV_X:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    // Keep the translation quotient and start on rotation.
                    quo_x_next   = div_q_step;
                    div_q_next   = mag_a_reg;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                end
            end
            tasms_pkg::CTRL_DIV_A:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
            end
            tasms_pkg::CTRL_DONE:
            begin
                res_write  = 1'b1;
                cnt_t_next = quo_x_wide[CNT_W-1:0];
                cnt_r_next = quo_a_wide[CNT_W-1:0];
                if ((quo_x_wide[CNT_W-1:0] == '0) && (quo_a_wide[CNT_W-1:0] == '0))
                begin
                    go_idle = 1'b1;
                end
                else
                begin
                    mode_next  = tasms_pkg::MODE_MOVE;
                    dir_next   = {back_a_reg, back_x_reg};
                    step_next  = 1'b1;
                    phase_next = '0;
                end
            end
            default: ;
        endcase

        if (clear_pos)
        begin
            pos_x_next = '0;
            pos_a_next = '0;
        end
        if (go_idle)
        begin
            mode_next  = tasms_pkg::MODE_IDLE;
            dir_next   = 2'b00;
            step_next  = 1'b0;
            phase_next = '0;
            cnt_t_next = '0;
            cnt_r_next = '0;
        end

        // The output register empties when taken and fills with each result.
        out_valid_next = out_valid_reg && !out_fire;
        out_data_next  = out_data_reg;
        if (res_write)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pin_levels(mode_next, cnt_t_next, cnt_r_next, step_next,
                                        dir_next, res_ignored);
        end
    end

    // ------------------------------------------------------------------
    // Control and motion state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_state_reg <= tasms_pkg::CTRL_IDLE;
            mode_reg       <= tasms_pkg::MODE_IDLE;
            dir_reg        <= 2'b00;
            step_reg       <= 1'b0;
            phase_reg      <= '0;
            cnt_t_reg      <= '0;
            cnt_r_reg      <= '0;
            pos_x_reg      <= '0;
            pos_a_reg      <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctrl_state_reg <= ctrl_state_next;
            mode_reg       <= mode_next;
            dir_reg        <= dir_next;
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            cnt_t_reg      <= cnt_t_next;
            cnt_r_reg      <= cnt_r_next;
            pos_x_reg      <= pos_x_next;
            pos_a_reg      <= pos_a_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers of the divider and of the output beat.
    always_ff @(posedge clk)
    begin
        delta_x_reg  <= delta_x_next;
        delta_a_reg  <= delta_a_next;
        mag_a_reg    <= mag_a_next;
        back_x_reg   <= back_x_next;
        back_a_reg   <= back_a_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        quo_x_reg    <= quo_x_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
module tb;
    import tasms_pkg::*;

    // The fourth opcode value has no meaning; the block must let it pass untouched.
    localparam logic [IN_USER_WIDTH-1:0] OP_SPARE = 2'd3;

    // Watchdog: cycles without any beat or register access before the run gives up.
    // The slowest quiet stretch is the one long receiver hold of LONG_HOLD_CYCLES.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    // Settling time after draining, longer than a move beat takes to come out.
    localparam int SETTLE_CYCLES    = 40;

    // One input beat, unpacked from tuser and tdata.
    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] target_x;
        logic signed [15:0] target_angle;
        logic               home_switch;
    } stepper_cmd_t;

    // Register contents as the predictor sees them.
    typedef struct {
        logic [HALF_WIDTH-1:0] half;
        logic [UNIT_WIDTH-1:0] mm;
        logic [UNIT_WIDTH-1:0] deg;
    } axis_cfg_t;

    // Motion state of both axes.
    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_angle;
        logic [16:0]        x_left;
        logic [16:0]        a_left;
        logic [19:0]        phase;
        logic               step_hi;
        seq_mode_t          mode;
        logic [1:0]         dir_back;   // bit 0 translation, bit 1 rotation
    } stepper_t;

    // Output beat fields, lowest bit last so that a cast from tdata lines up.
    typedef struct packed {
        logic ignored;
        logic busy;
        logic dir_r_back;
        logic dir_t_back;
        logic step_r;
        logic step_t;
    } pin_levels_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    wire                          s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]     s_axis_tdata = '0;
    logic [IN_USER_WIDTH-1:0]     s_axis_tuser = '0;
    wire                          m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    wire  [OUT_DATA_WIDTH-1:0]    m_axis_tdata;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0]    paddr = '0;
    logic [APB_DATA_WIDTH-1:0]    pwdata = '0;
    wire  [APB_DATA_WIDTH-1:0]    prdata;
    wire                          pready;

    two_axis_stepper_move_sequencer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    // Commands waiting to be driven, the command on the bus, and the pin levels
    // that each taken beat should produce, oldest first.
    stepper_cmd_t pending_cmds[$];
    stepper_cmd_t cmd_in_flight;
    pin_levels_t  expected_pins[$];

    // Two copies of the motion state: live_state advances on every taken beat and
    // feeds the checks; plan_state advances as commands are queued, so that the
    // stimulus knows whether the axes will be moving, homing or idle.
    stepper_t  live_state;
    stepper_t  plan_state;
    axis_cfg_t axis_cfg = '{HALF_PERIOD_RESET, UNIT_RESET, UNIT_RESET};

    int cmds_offered = 0;
    int cmds_accepted = 0;
    int results_seen = 0;
    int pin_mismatches = 0;
    int readback_mismatches = 0;
    int phase_items = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int send_gap = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int quiet_cycles = 0;

    function automatic stepper_t reset_stepper();
        stepper_t s;
        s.pos_x = '0;
        s.pos_angle = '0;
        s.x_left = '0;
        s.a_left = '0;
        s.phase = '0;
        s.step_hi = 1'b0;
        s.mode = MODE_IDLE;
        s.dir_back = 2'b00;
        return s;
    endfunction

    // Ends any motion: pins forward and low, counters cleared. Positions stay.
    function automatic void stop_motion(inout stepper_t s);
        s.mode = MODE_IDLE;
        s.dir_back = 2'b00;
        s.step_hi = 1'b0;
        s.phase = '0;
        s.x_left = '0;
        s.a_left = '0;
    endfunction

    // Pulses for one axis: |target - position| / units per pulse, truncated.
    // A zero divisor behaves as one.
    function automatic logic [16:0] pulse_count(input int target, input int current,
                                                input logic [7:0] per_pulse,
                                                output logic back);
        int delta;
        int divisor;
        delta = target - current;
        back = (delta < 0);
        divisor = (per_pulse == '0) ? 1 : int'(per_pulse);
        if (delta < 0)
        begin
            delta = -delta;
        end
        return 17'(delta / divisor);
    endfunction

    // Applies one beat to the motion state and returns the pin levels after it.
    function automatic pin_levels_t advance_stepper(inout stepper_t s, input axis_cfg_t c,
                                                    input stepper_cmd_t cmd);
        pin_levels_t lv;
        logic [19:0] half;
        logic        t_back;
        logic        r_back;
        logic        t_act;
        logic        r_act;
        lv = '0;
        half = (c.half == '0) ? 20'd1 : c.half;
        if (cmd.op == OP_MOVE || cmd.op == OP_HOME)
        begin
            if (s.mode != MODE_IDLE)
            begin
                // Commands are dropped while a move or homing runs.
                lv.ignored = 1'b1;
            end
            else if (cmd.op == OP_MOVE)
            begin
                s.x_left = pulse_count(int'(cmd.target_x), int'(s.pos_x), c.mm, t_back);
                s.a_left = pulse_count(int'(cmd.target_angle), int'(s.pos_angle), c.deg,
                                       r_back);
                s.pos_x = cmd.target_x;
                s.pos_angle = cmd.target_angle;
                if (s.x_left == '0 && s.a_left == '0)
                begin
                    stop_motion(s);
                end
                else
                begin
                    s.mode = MODE_MOVE;
                    s.dir_back = {r_back, t_back};
                    s.step_hi = 1'b1;
                    s.phase = '0;
                end
            end
            else if (cmd.home_switch)
            begin
                s.pos_x = '0;
                s.pos_angle = '0;
                stop_motion(s);
            end
            else
            begin
                s.mode = MODE_HOME;
                s.dir_back = 2'b01;
                s.step_hi = 1'b1;
                s.phase = '0;
            end
        end
        else if (cmd.op == OP_TICK && s.mode != MODE_IDLE)
        begin
            s.phase = s.phase + 20'd1;
            if (s.phase >= half || s.phase == '0)
            begin
                s.phase = '0;
                if (s.step_hi)
                begin
                    s.step_hi = 1'b0;
                end
                else if (s.mode == MODE_HOME)
                begin
                    // The switch only counts at the end of a whole pulse.
                    if (cmd.home_switch)
                    begin
                        s.pos_x = '0;
                        s.pos_angle = '0;
                        stop_motion(s);
                    end
                    else
                    begin
                        s.step_hi = 1'b1;
                    end
                end
                else
                begin
                    if (s.x_left != '0)
                    begin
                        s.x_left = s.x_left - 17'd1;
                    end
                    else if (s.a_left != '0)
                    begin
                        s.a_left = s.a_left - 17'd1;
                    end
                    if (s.x_left == '0 && s.a_left == '0)
                    begin
                        stop_motion(s);
                    end
                    else
                    begin
                        s.step_hi = 1'b1;
                    end
                end
            end
        end
        // Translation pulses go out first, then rotation; each direction pin
        // shows backward only while its own axis is the one stepping.
        t_act = (s.mode == MODE_HOME) || (s.mode == MODE_MOVE && s.x_left != '0);
        r_act = (s.mode == MODE_MOVE) && (s.x_left == '0) && (s.a_left != '0);
        lv.step_t = t_act && s.step_hi;
        lv.step_r = r_act && s.step_hi;
        lv.dir_t_back = t_act && s.dir_back[0];
        lv.dir_r_back = r_act && s.dir_back[1];
        lv.busy = (s.mode != MODE_IDLE);
        return lv;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stepper_cmd_t make_cmd(input logic [1:0] op, input int tx, input int ta,
                                              input logic sw);
        stepper_cmd_t cmd;
        cmd.op = op;
        cmd.target_x = 16'(tx);
        cmd.target_angle = 16'(ta);
        cmd.home_switch = sw;
        return cmd;
    endfunction

    function automatic stepper_cmd_t rand_cmd(input logic [1:0] op);
        return make_cmd(op, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                        1'($urandom));
    endfunction

    // Commands that are dropped or meaningless when they land mid-motion.
    function automatic logic [1:0] stray_op();
        case ($urandom_range(0, 2))
            0: return OP_MOVE;
            1: return OP_HOME;
            default: return OP_SPARE;
        endcase
    endfunction

    // A target a few pulses away from the current position, zero pulses included,
    // kept inside the signed 16-bit range.
    function automatic logic [15:0] near_target(input logic signed [15:0] pos,
                                                input logic [7:0] per_pulse);
        int step_units;
        int span;
        int t;
        step_units = (per_pulse == '0) ? 1 : int'(per_pulse);
        span = step_units * int'($urandom_range(0, 6)) + int'($urandom_range(0, step_units));
        t = int'(pos) + int'($urandom_range(0, 2 * span)) - span;
        if (t > 32767)
        begin
            t = 32767;
        end
        if (t < -32768)
        begin
            t = -32768;
        end
        return 16'(t);
    endfunction

    task automatic queue_cmd(input stepper_cmd_t cmd);
        pin_levels_t unused;
        unused = advance_stepper(plan_state, axis_cfg, cmd);
        pending_cmds.push_back(cmd);
        phase_items++;
    endtask

    // Feeds ticks until the planned motion is over. Now and then a command is
    // thrown in while busy, which the block must drop. During homing the switch
    // reads high now and then, so that it lands both mid-pulse and at pulse ends.
    task automatic run_to_idle();
        stepper_cmd_t cmd;
        while (plan_state.mode != MODE_IDLE)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                cmd = rand_cmd(stray_op());
            end
            else
            begin
                cmd = rand_cmd(OP_TICK);
                if (plan_state.mode == MODE_HOME)
                begin
                    cmd.home_switch = ($urandom_range(0, 5) == 0);
                end
            end
            queue_cmd(cmd);
        end
    endtask

    // One well-formed sequence (move or home followed by its ticks), or a stray
    // beat while idle.
    task automatic queue_sequence();
        stepper_cmd_t cmd;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            cmd = rand_cmd(OP_MOVE);
            cmd.target_x = near_target(plan_state.pos_x, axis_cfg.mm);
            cmd.target_angle = near_target(plan_state.pos_angle, axis_cfg.deg);
        end
        else if (pick < 75)
        begin
            cmd = rand_cmd(OP_HOME);
            cmd.home_switch = ($urandom_range(0, 4) == 0);
        end
        else if (pick < 92)
        begin
            cmd = rand_cmd(OP_TICK);
        end
        else
        begin
            cmd = rand_cmd(OP_SPARE);
        end
        queue_cmd(cmd);
        run_to_idle();
    endtask

    task automatic run_phase(input int items);
        phase_items = 0;
        while (phase_items < items)
        begin
            queue_sequence();
        end
    endtask

    // Holds the sender until every queued beat is taken and answered.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmds_accepted != cmds_offered ||
               expected_pins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_WIDTH-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_readback(input logic [1:0] idx, input logic [APB_DATA_WIDTH-1:0] want);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("register %0d readback: expected %0h, actual %0h", idx, want, prdata);
            readback_mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called while the block is idle and every result is in.
    task automatic set_config(input logic [19:0] half, input logic [7:0] mm,
                              input logic [7:0] deg);
        apb_write(REG_HALF_PERIOD, 32'(half));
        apb_write(REG_MM_PER_PULSE, 32'(mm));
        apb_write(REG_DEG_PER_PULSE, 32'(deg));
        axis_cfg.half = half;
        axis_cfg.mm = mm;
        axis_cfg.deg = deg;
        apb_readback(REG_HALF_PERIOD, 32'(half));
        apb_readback(REG_MM_PER_PULSE, 32'(mm));
        apb_readback(REG_DEG_PER_PULSE, 32'(deg));
    endtask

    task automatic compare_pin(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            pin_mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: presents the next command at the falling edge once the
    // previous beat has been taken, with random gaps between beats.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && cmds_accepted == cmds_offered)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd_in_flight = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cmd_in_flight.op;
                s_axis_tdata <= {7'd0, cmd_in_flight.home_switch,
                                 cmd_in_flight.target_angle, cmd_in_flight.target_x};
                cmds_offered++;
                if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
                begin
                    send_gap = $urandom_range(1, 17);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: random stalls, plus one long hold while commands are still
    // queued, so the output register fills up and the block has to push back on
    // its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (!long_hold_done && results_seen > 200 && pending_cmds.size() > 40)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct)
            begin
                hold_left = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts each taken input beat and checks each output beat
    // against the oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pin_levels_t want;
        pin_levels_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_pins.push_back(advance_stepper(live_state, axis_cfg, cmd_in_flight));
                cmds_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got = pin_levels_t'(m_axis_tdata[RESULT_WIDTH-1:0]);
                if (expected_pins.size() == 0)
                begin
                    $error("output beat %0h arrived with no command waiting", m_axis_tdata);
                    pin_mismatches++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    compare_pin("step_translate", want.step_t, got.step_t);
                    compare_pin("step_rotate", want.step_r, got.step_r);
                    compare_pin("dir_translate_back", want.dir_t_back, got.dir_t_back);
                    compare_pin("dir_rotate_back", want.dir_r_back, got.dir_r_back);
                    compare_pin("busy_res", want.busy, got.busy);
                    compare_pin("command_ignored", want.ignored, got.ignored);
                end
            end
        end
    end

    // Watchdog: too long without any beat or register access means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("two_axis_stepper_move_sequencer_core verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        live_state = reset_stepper();
        plan_state = reset_stepper();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults after reset, and a few beats that finish at once
        // under the default half period.
        apb_readback(REG_HALF_PERIOD, 32'(HALF_PERIOD_RESET));
        apb_readback(REG_MM_PER_PULSE, 32'(UNIT_RESET));
        apb_readback(REG_DEG_PER_PULSE, 32'(UNIT_RESET));
        send_gap_pct = 20;
        recv_gap_pct = 8;
        queue_cmd(make_cmd(OP_TICK, 0, 0, 1'b0));
        queue_cmd(make_cmd(OP_MOVE, 0, 0, 1'b0));
        queue_cmd(make_cmd(OP_HOME, 0, 0, 1'b1));
        wait_drained();

        // Directed: unknown opcode with every target and switch bit set, an idle
        // tick, a move forward on translation and backward on rotation with commands
        // thrown in mid-move, homing that ends at once and homing that takes pulses.
        set_config(20'd1, 8'd1, 8'd1);
        queue_cmd(make_cmd(OP_SPARE, -1, -1, 1'b1));
        queue_cmd(make_cmd(OP_TICK, 0, 0, 1'b0));
        queue_cmd(make_cmd(OP_MOVE, 3, -2, 1'b0));
        queue_cmd(make_cmd(OP_TICK, 0, 0, 1'b1));
        queue_cmd(make_cmd(OP_MOVE, 32767, -32768, 1'b1));
        queue_cmd(make_cmd(OP_HOME, -32768, 32767, 1'b1));
        run_to_idle();
        queue_cmd(make_cmd(OP_HOME, 0, 0, 1'b1));
        queue_cmd(make_cmd(OP_HOME, 0, 0, 1'b0));
        queue_cmd(make_cmd(OP_TICK, 0, 0, 1'b1));
        queue_cmd(make_cmd(OP_TICK, 0, 0, 1'b0));
        run_to_idle();
        wait_drained();

        // Directed at the widest unit per pulse: a move to the corners of the
        // target range, a rotation-only and a translation-only single pulse, and
        // a move one unit short of a pulse, which truncates to nothing.
        set_config(20'd1, 8'd255, 8'd255);
        queue_cmd(make_cmd(OP_MOVE, -32768, 32767, 1'b0));
        run_to_idle();
        queue_cmd(make_cmd(OP_MOVE, -32768, 32512, 1'b0));
        run_to_idle();
        queue_cmd(make_cmd(OP_MOVE, -32513, 32512, 1'b0));
        run_to_idle();
        queue_cmd(make_cmd(OP_MOVE, -32259, 32512, 1'b0));
        wait_drained();

        // Random phases. The first is long enough for the receiver's long hold.
        set_config(20'd1, 8'd7, 8'd3);
        run_phase(450);
        wait_drained();

        // Zero half period and zero units per pulse both behave as one.
        set_config(20'd0, 8'd0, 8'd0);
        run_phase(300);
        wait_drained();

        // A stretch where the sender never idles.
        send_gap_pct = 0;
        set_config(20'd3, 8'd255, 8'd128);
        run_phase(350);
        wait_drained();

        send_gap_pct = 20;
        set_config(20'd2, 8'd1, 8'd255);
        run_phase(300);
        wait_drained();

        // Last part, no idling on either side: the longest half period, so a
        // started move keeps stepping and later commands are dropped.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_config(20'd1000000, 8'd20, 8'd5);
        phase_items = 0;
        while (phase_items < 80)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                queue_cmd(rand_cmd(OP_TICK));
            end
            else
            begin
                queue_cmd(rand_cmd(stray_op()));
            end
        end
        wait_drained();

        if (expected_pins.size() != 0)
        begin
            $error("%0d expected output beats never arrived", expected_pins.size());
        end
        if (pin_mismatches == 0 && readback_mismatches == 0 && expected_pins.size() == 0)
        begin
            $display("two_axis_stepper_move_sequencer_core verification clean");
        end
        else
        begin
            $display("two_axis_stepper_move_sequencer_core verification failed");
        end
        $finish;
    end

endmodule

// File: two_axis_stepper_move_sequencer_core.f
rtl/tasms_pkg.sv
rtl/two_axis_stepper_move_sequencer_core.sv
dv/tb.sv
